### rtl/ols_pkg.sv
// Shared types and constants for the ordered list store.
package ols_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VAL_W        = 32;
	localparam int POS_W        = 8;
	localparam int IDX_OUT_W    = 7;

	typedef enum logic [2:0] {
		F_INS_HEAD = 3'd0,
		F_INS_TAIL = 3'd1,
		F_INS_POS  = 3'd2,
		F_DEL_HEAD = 3'd3,
		F_DEL_TAIL = 3'd4,
		F_DEL_VAL  = 3'd5,
		F_SEARCH   = 3'd6,
		F_DUMP     = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		func_t                    func;
		logic signed [VAL_W-1:0]  value;
		logic [POS_W-1:0]         position;
	} req_t;

	typedef struct packed {
		status_t                  status;
		logic                     found;
		logic signed [VAL_W-1:0]  item;
		logic [IDX_OUT_W-1:0]     item_index;
		logic [IDX_OUT_W-1:0]     count;
		logic                     last;
	} rsp_t;

endpackage

### rtl/ols_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module ols_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/ordered_list_store.sv
// Ordered list store: top level with request sequencer and element RAM.
//
// Usage: drive req (func, value, position) and raise start while busy is low;
// the beat is taken at that edge and busy rises after it, unless the request
// is answered at once. Results come back on rsp, each valid for exactly one
// cycle while rsp_valid is high; the receiver cannot stall, so results must be
// sampled as they appear. Every request gives one result, except dump, which
// gives one beat per element in list order with item_index 1..count and last
// on the final one. Empty-list, not-found and full cases set the status.
//
// Sequencing: full and empty cases are answered by the accepting edge itself.
// An insert moves the entries from the tail down to the target up by one, then
// writes the value; a remove moves the entries after the target down over it.
// A search scans from the head and stops at a hit; a remove by value scans and
// then moves the tail down over the hit; a dump gives one beat per cycle.
// Shifts and scans move one entry per cycle through the single read and write
// port, with the read data registered. busy is low again in the cycle that
// carries the last result. Reset clears the element count; the RAM is not
// cleared, as no entry at or above the count is ever read.
module ordered_list_store import ols_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic rsp_valid,
	output rsp_t rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_SCAN,
		S_DUMP
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           left_q;
	logic [AW-1:0]           ptr_q;
	logic [AW-1:0]           idx_q;
	func_t                   func_q;
	logic signed [VAL_W-1:0] value_q;
	logic signed [VAL_W-1:0] item_q;
	logic                    pend_s1;
	logic [AW-1:0]           src_s1;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [VAL_W-1:0]        ram_wdata;
	logic                    ram_re;
	logic [VAL_W-1:0]        ram_rdata;

	logic [CW-1:0]           idx_ins;
	logic                    match;

	ols_ram #(
		.W     (VAL_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	function automatic rsp_t mk_rsp(status_t st, logic fnd, logic [VAL_W-1:0] itm,
			logic [IDX_OUT_W-1:0] ix, logic [CW-1:0] cnt, logic lst);
		rsp_t r;
		r.status     = st;
		r.found      = fnd;
		r.item       = itm;
		r.item_index = ix;
		r.count      = IDX_OUT_W'(cnt);
		r.last       = lst;
		return r;
	endfunction

	// insert target entry, with the position clamped to head or tail
	always_comb begin
		priority if (req.func == F_INS_HEAD ||
				(req.func == F_INS_POS && req.position <= POS_W'(1))) begin
			idx_ins = '0;
		end else if (req.func == F_INS_TAIL ||
				{1'b0, req.position} >= (9'(cnt_q) + 9'd1)) begin
			idx_ins = cnt_q;
		end else begin
			idx_ins = CW'(req.position - POS_W'(1));
		end
	end

	// a hit only counts while scanning; it stops the walk
	assign match = pend_s1 && (state_q == S_SCAN) && (ram_rdata == value_q);

	always_comb begin
		ram_re    = (state_q != S_IDLE) && (left_q != '0);
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = value_q;
		unique case (state_q)
			S_SHIFT_UP: begin
				if (pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = src_s1 + AW'(1);
					ram_wdata = ram_rdata;
				end else if (left_q == '0) begin
					ram_we = 1'b1;
				end
			end
			S_SHIFT_DN: begin
				// the entry being removed is captured, not moved
				if (pend_s1 && src_s1 != idx_q) begin
					ram_we    = 1'b1;
					ram_waddr = src_s1 - AW'(1);
					ram_wdata = ram_rdata;
				end
			end
			S_IDLE, S_SCAN, S_DUMP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			left_q      <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= 1'b0;
			if (state_q != S_IDLE && left_q != '0 && !match) begin
				ptr_q   <= (state_q == S_SHIFT_UP) ? ptr_q - AW'(1) : ptr_q + AW'(1);
				left_q  <= left_q - CW'(1);
				pend_s1 <= 1'b1;
				src_s1  <= ptr_q;
			end else begin
				pend_s1 <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q  <= req.func;
						value_q <= req.value;
						unique case (req.func)
							F_INS_HEAD, F_INS_TAIL, F_INS_POS: begin
								if (cnt_q == CW'(CAPACITY)) begin
									rsp_valid_q <= 1'b1;
									rsp_q <= mk_rsp(ST_FULL, 1'b0, '0, '0, cnt_q, 1'b1);
								end else begin
									idx_q   <= AW'(idx_ins);
									ptr_q   <= AW'(cnt_q - CW'(1));
									left_q  <= cnt_q - idx_ins;
									state_q <= S_SHIFT_UP;
								end
							end
							F_DEL_HEAD, F_DEL_TAIL: begin
								if (cnt_q == '0) begin
									rsp_valid_q <= 1'b1;
									rsp_q <= mk_rsp(ST_EMPTY, 1'b0, '0, '0, cnt_q, 1'b1);
								end else if (req.func == F_DEL_HEAD) begin
									idx_q   <= '0;
									ptr_q   <= '0;
									left_q  <= cnt_q;
									state_q <= S_SHIFT_DN;
								end else begin
									idx_q   <= AW'(cnt_q - CW'(1));
									ptr_q   <= AW'(cnt_q - CW'(1));
									left_q  <= CW'(1);
									state_q <= S_SHIFT_DN;
								end
							end
							F_DEL_VAL, F_SEARCH, F_DUMP: begin
								if (cnt_q == '0) begin
									rsp_valid_q <= 1'b1;
									rsp_q <= mk_rsp(ST_EMPTY, 1'b0, '0, '0, cnt_q, 1'b1);
								end else begin
									ptr_q   <= '0;
									left_q  <= cnt_q;
									state_q <= (req.func == F_DUMP) ? S_DUMP : S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SHIFT_UP: begin
					if (!pend_s1 && left_q == '0) begin
						cnt_q       <= cnt_q + CW'(1);
						rsp_valid_q <= 1'b1;
						rsp_q       <= mk_rsp(ST_OK, 1'b0, '0, '0, cnt_q + CW'(1), 1'b1);
						state_q     <= S_IDLE;
					end
				end
				S_SHIFT_DN: begin
					if (pend_s1 && src_s1 == idx_q) begin
						item_q <= ram_rdata;
					end
					if (!pend_s1 && left_q == '0) begin
						cnt_q       <= cnt_q - CW'(1);
						rsp_valid_q <= 1'b1;
						rsp_q       <= mk_rsp(ST_OK, 1'b0, item_q, '0, cnt_q - CW'(1), 1'b1);
						state_q     <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (match) begin
						if (func_q == F_SEARCH) begin
							rsp_valid_q <= 1'b1;
							rsp_q       <= mk_rsp(ST_OK, 1'b1, '0, '0, cnt_q, 1'b1);
							state_q     <= S_IDLE;
						end else begin
							// restart at the hit and pull the tail down over it
							idx_q   <= src_s1;
							ptr_q   <= src_s1;
							left_q  <= cnt_q - CW'(src_s1);
							state_q <= S_SHIFT_DN;
						end
					end else if (!pend_s1 && left_q == '0) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= mk_rsp(ST_NOTFOUND, 1'b0, '0, '0, cnt_q, 1'b1);
						state_q     <= S_IDLE;
					end
				end
				S_DUMP: begin
					if (pend_s1) begin
						rsp_valid_q <= 1'b1;
						rsp_q <= mk_rsp(ST_OK, 1'b0, ram_rdata,
							IDX_OUT_W'(src_s1) + IDX_OUT_W'(1), cnt_q,
							CW'(src_s1) == cnt_q - CW'(1));
						if (CW'(src_s1) == cnt_q - CW'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_we)
		else $error("RAM written while idle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.last) |-> !busy)
		else $error("busy still high on last result beat");

	a_pend_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 && !$past(state_q == S_IDLE)) |-> $past(ram_re))
		else $error("pending read data without a read");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !((req.func == F_INS_HEAD || req.func == F_INS_TAIL ||
			req.func == F_INS_POS) && cnt_q == CW'(CAPACITY)) && cnt_q != '0) |=> busy)
		else $error("accepted request did not start a sequence");

endmodule
